[src/i2cm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the acked-register-access I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int unsigned MAX_READ_LENGTH_DEF = 256;
	localparam logic [15:0] DELAY_TICKS_RESET   = 16'd100;
	localparam logic [3:0]  BYTE_BITS           = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'd0,
		ST_START_A   = 4'd1,
		ST_START_B   = 4'd2,
		ST_START_C   = 4'd3,
		ST_TX_SET    = 4'd4,
		ST_TX_HIGH   = 4'd5,
		ST_ACK_SETUP = 4'd6,
		ST_ACK_HIGH  = 4'd7,
		ST_ACK_END   = 4'd8,
		ST_RX_LOW    = 4'd9,
		ST_RX_HIGH   = 4'd10,
		ST_RACK_SET  = 4'd11,
		ST_RACK_HIGH = 4'd12,
		ST_STOP_A    = 4'd13,
		ST_STOP_B    = 4'd14
	} step_t;

	typedef enum logic [1:0] {
		BS_DEVICE   = 2'd0,
		BS_REGISTER = 2'd1,
		BS_VALUE    = 2'd2,
		BS_READ_DEV = 2'd3
	} byte_stage_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_enable;
		logic       busy_res;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       done_res;
		logic       nack_error;
	} result_t;

endpackage

[src/i2cm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances one step once the accepted ticks reach the delay, computes the result.
// ----------------------------------------------------------------------------
module i2cm_seq
	import i2cm_pkg::*;
#(
	parameter int unsigned MAX_READ_LENGTH = MAX_READ_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        accept,
	input  logic        kind,
	input  logic        operation,
	input  logic [7:0]  device_byte,
	input  logic [7:0]  register_address,
	input  logic [7:0]  write_value,
	input  logic [8:0]  read_length,
	input  logic        sda_in,
	output result_t     result
);

	localparam int unsigned CW = $clog2(MAX_READ_LENGTH + 1);
	localparam int unsigned LW = (CW > 9) ? CW : 9;
	localparam logic [CW-1:0] REM_ONE = CW'(1);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_READ_LENGTH);

	step_t       step_q, n_step;
	byte_stage_t stage_q, n_stage;
	logic [15:0] dly_q, cnt_q, n_cnt;
	logic [3:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [CW-1:0] rem_q, n_rem;
	logic [7:0]  dev_q, n_dev, reg_q, n_reg, val_q, n_val;
	logic        op_q, n_op, abort_q, n_abort;
	logic        scl_q, n_scl, sda_q, n_sda, en_q, n_en;
	logic        fire;

	always_comb begin
		logic [15:0]   limit;
		logic [15:0]   cnt_inc;
		logic [LW-1:0] len;
		n_step  = step_q;
		n_stage = stage_q;
		n_cnt   = cnt_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_rem   = rem_q;
		n_dev   = dev_q;
		n_reg   = reg_q;
		n_val   = val_q;
		n_op    = op_q;
		n_abort = abort_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_en    = en_q;
		fire    = 1'b0;
		limit   = (dly_q == 16'd0) ? 16'd1 : dly_q;
		cnt_inc = cnt_q + 16'd1;
		len     = LW'(read_length);
		if (len == '0) begin
			len = LW'(1);
		end
		if (len > LEN_MAX) begin
			len = LEN_MAX;
		end
		if (accept) begin
			if (!kind) begin
				if (step_q == ST_IDLE) begin
					n_op    = operation;
					n_dev   = device_byte;
					n_reg   = register_address;
					n_val   = write_value;
					n_rem   = CW'(len);
					n_stage = BS_DEVICE;
					n_abort = 1'b0;
					n_cnt   = '0;
					n_bit   = '0;
					n_shift = device_byte;
					n_step  = ST_START_A;
					n_scl   = 1'b1;
					n_sda   = 1'b1;
					n_en    = 1'b1;
				end
			end else if (step_q != ST_IDLE) begin
				if (cnt_inc >= limit) begin
					n_cnt = '0;
					fire  = 1'b1;
					case (step_q)
						ST_START_A: begin
							n_step = ST_START_B; n_scl = 1'b1; n_sda = 1'b0; n_en = 1'b1;
						end
						ST_START_B: begin
							n_step = ST_START_C; n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1;
						end
						ST_START_C: begin
							n_bit  = '0;
							n_step = ST_TX_SET; n_scl = 1'b0; n_sda = shift_q[7]; n_en = 1'b1;
						end
						ST_TX_SET: begin
							n_step = ST_TX_HIGH; n_scl = 1'b1; n_sda = shift_q[7]; n_en = 1'b1;
						end
						ST_TX_HIGH: begin
							n_shift = {shift_q[6:0], 1'b0};
							n_bit   = bit_q + 4'd1;
							if (n_bit >= BYTE_BITS) begin
								n_step = ST_ACK_SETUP; n_scl = 1'b0; n_sda = 1'b1; n_en = 1'b0;
							end else begin
								n_step = ST_TX_SET; n_scl = 1'b0; n_sda = shift_q[6]; n_en = 1'b1;
							end
						end
						ST_ACK_SETUP: begin
							n_step = ST_ACK_HIGH; n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b0;
						end
						ST_ACK_HIGH: begin
							// nack from the slave: go straight to stop
							if (sda_in) begin
								n_abort = 1'b1;
								n_step = ST_STOP_A; n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1;
							end else begin
								n_step = ST_ACK_END; n_scl = 1'b0; n_sda = 1'b1; n_en = 1'b1;
							end
						end
						ST_ACK_END: begin
							case (stage_q)
								BS_DEVICE: begin
									n_stage = BS_REGISTER;
									n_shift = reg_q;
									n_bit   = '0;
									n_step = ST_TX_SET; n_scl = 1'b0; n_sda = reg_q[7]; n_en = 1'b1;
								end
								BS_REGISTER: begin
									if (!op_q) begin
										n_stage = BS_VALUE;
										n_shift = val_q;
										n_bit   = '0;
										n_step = ST_TX_SET; n_scl = 1'b0; n_sda = val_q[7];
										n_en   = 1'b1;
									end else begin
										// repeated start, then device byte with read bit
										n_stage = BS_READ_DEV;
										n_shift = dev_q + 8'd1;
										n_step = ST_START_A; n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b1;
									end
								end
								BS_VALUE: begin
									n_step = ST_STOP_A; n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1;
								end
								default: begin
									n_bit   = '0;
									n_shift = '0;
									n_step = ST_RX_LOW; n_scl = 1'b0; n_sda = 1'b1; n_en = 1'b0;
								end
							endcase
						end
						ST_RX_LOW: begin
							n_step = ST_RX_HIGH; n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b0;
						end
						ST_RX_HIGH: begin
							n_shift = {shift_q[6:0], sda_in};
							n_bit   = bit_q + 4'd1;
							if (n_bit >= BYTE_BITS) begin
								// ack every byte but the last
								n_step = ST_RACK_SET; n_scl = 1'b0; n_sda = (rem_q <= REM_ONE);
								n_en   = 1'b1;
							end else begin
								n_step = ST_RX_LOW; n_scl = 1'b0; n_sda = 1'b1; n_en = 1'b0;
							end
						end
						ST_RACK_SET: begin
							n_step = ST_RACK_HIGH; n_scl = 1'b1; n_sda = sda_q; n_en = 1'b1;
						end
						ST_RACK_HIGH: begin
							if (rem_q != '0) begin
								n_rem = rem_q - REM_ONE;
							end
							if (rem_q <= REM_ONE) begin
								n_step = ST_STOP_A; n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1;
							end else begin
								n_bit   = '0;
								n_shift = '0;
								n_step = ST_RX_LOW; n_scl = 1'b0; n_sda = 1'b1; n_en = 1'b0;
							end
						end
						ST_STOP_A: begin
							n_step = ST_STOP_B; n_scl = 1'b1; n_sda = 1'b0; n_en = 1'b1;
						end
						ST_STOP_B: begin
							n_abort = 1'b0;
							n_step = ST_IDLE; n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b1;
						end
						default: begin
							n_step = ST_IDLE; n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b1;
						end
					endcase
				end else begin
					n_cnt = cnt_inc;
				end
			end
		end
	end

	always_comb begin
		result            = '0;
		result.scl_out    = n_scl;
		result.sda_out    = n_sda;
		result.sda_enable = n_en;
		result.busy_res   = (n_step != ST_IDLE);
		if (fire && step_q == ST_RACK_HIGH) begin
			result.read_valid = 1'b1;
			result.read_data  = shift_q;
			result.read_last  = (rem_q <= REM_ONE);
		end
		if (fire && step_q == ST_STOP_B) begin
			result.done_res   = 1'b1;
			result.nack_error = abort_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			stage_q <= BS_DEVICE;
			dly_q   <= DELAY_TICKS_RESET;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			rem_q   <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			val_q   <= '0;
			op_q    <= 1'b0;
			abort_q <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			en_q    <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				dly_q <= cfg_wr_data;
			end
			step_q  <= n_step;
			stage_q <= n_stage;
			cnt_q   <= n_cnt;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			rem_q   <= n_rem;
			dev_q   <= n_dev;
			reg_q   <= n_reg;
			val_q   <= n_val;
			op_q    <= n_op;
			abort_q <= n_abort;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			en_q    <= n_en;
		end
	end

`ifndef SYNTH
	// a command taken while idle always opens with a start condition
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !kind && step_q == ST_IDLE) |=> (step_q == ST_START_A))
		else $error("command while idle did not start a transaction");

	// the bus is released only while the slave drives data or ack
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		!en_q |-> (step_q == ST_ACK_SETUP || step_q == ST_ACK_HIGH ||
			step_q == ST_RX_LOW || step_q == ST_RX_HIGH))
		else $error("sda released outside a receive phase");

	// completion ends the transaction and leaves the lines idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && result.done_res) |=> (step_q == ST_IDLE && scl_q && sda_q && en_q))
		else $error("done without returning to idle");

	// a received byte always belongs to a burst with bytes left
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.read_valid |-> (rem_q != '0 && op_q))
		else $error("read byte outside a burst read");
`endif

endmodule

[src/i2c_master_acked_register_access.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_acked_register_access
// I2C master for register writes and burst register reads with ack checking.
// ----------------------------------------------------------------------------
// Usage:
// - the input channel (in_valid / in_stall) carries one item per transfer:
//   kind 0 is a command (acted on only while idle), kind 1 is a time tick
//   carrying the sampled sda level
// - every accepted item yields exactly one result on the output channel
//   (out_valid / out_stall) with the line levels, busy, read byte and done
// - delay_ticks (cfg_wr_en / cfg_wr_data) sets ticks per bus phase; write it
//   only while no transfer is in flight; a shorter value ends the running
//   phase on the next tick
// - the result is registered, valid in the cycle after the input transfer;
//   an item can be taken every cycle while in_stall is low; the sequencer
//   step logic sits between the state registers and the result register
// - when the receiver stalls, the result register holds and in_stall rises
//   until the result is taken; nothing is dropped
// - reset leaves the block idle with scl high, sda high and driven, and
//   delay_ticks at 100; no output is valid after reset
// ----------------------------------------------------------------------------
module i2c_master_acked_register_access
	import i2cm_pkg::*;
#(
	parameter int unsigned MAX_READ_LENGTH = MAX_READ_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic        operation,
	input  logic [7:0]  device_byte,
	input  logic [7:0]  register_address,
	input  logic [7:0]  write_value,
	input  logic [8:0]  read_length,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_out,
	output logic        sda_out,
	output logic        sda_enable,
	output logic        busy_res,
	output logic        read_valid,
	output logic [7:0]  read_data,
	output logic        read_last,
	output logic        done_res,
	output logic        nack_error
);

	logic    accept;
	logic    out_valid_q;
	result_t result;
	result_t result_q;

	// a new item is taken unless the held result is still blocked
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	i2cm_seq #(
		.MAX_READ_LENGTH(MAX_READ_LENGTH)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.accept          (accept),
		.kind            (kind),
		.operation       (operation),
		.device_byte     (device_byte),
		.register_address(register_address),
		.write_value     (write_value),
		.read_length     (read_length),
		.sda_in          (sda_in),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_out    = result_q.scl_out;
	assign sda_out    = result_q.sda_out;
	assign sda_enable = result_q.sda_enable;
	assign busy_res   = result_q.busy_res;
	assign read_valid = result_q.read_valid;
	assign read_data  = result_q.read_data;
	assign read_last  = result_q.read_last;
	assign done_res   = result_q.done_res;
	assign nack_error = result_q.nack_error;

endmodule

[dv/i2c_master_acked_register_access_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_acked_register_access_tb
// Self-checking bench for the I2C master sequencer. Commands and ticks are
// queued by a stimulus process that follows the bus sequence, so slave acks,
// NACK aborts and read data land on the right phases. A bus predictor
// computes the line levels, read bytes and finish flags of every transfer.
// The monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_acked_register_access_tb;
	import i2cm_pkg::*;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_READ   = 1'b1;
	localparam int   NO_NACK   = -1;

	typedef struct packed {
		logic       kind;
		logic       op;
		logic [7:0] dev;
		logic [7:0] reg_addr;
		logic [7:0] value;
		logic [8:0] rlen;
		logic       sda;
	} bus_item_t;

	typedef struct {
		step_t       step;
		logic [15:0] dcount;
		logic [3:0]  bit_idx;
		logic [7:0]  shreg;
		logic [8:0]  remaining;
		logic [7:0]  dev;
		logic [7:0]  reg_addr;
		logic [7:0]  value;
		logic        op;
		logic        scl;
		logic        sda;
		logic        en;
		byte_stage_t stage;
		logic        aborted;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic        operation = 1'b0;
	logic [7:0]  device_byte = '0;
	logic [7:0]  register_address = '0;
	logic [7:0]  write_value = '0;
	logic [8:0]  read_length = '0;
	logic        sda_in = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        sda_enable;
	logic        busy_res;
	logic        read_valid;
	logic [7:0]  read_data;
	logic        read_last;
	logic        done_res;
	logic        nack_error;

	bus_item_t   item_q[$];
	result_t     bus_expect_q[$];
	seq_state_t  plan_state;
	seq_state_t  check_state;
	bus_item_t   cur_item;
	result_t     predicted;
	result_t     want;
	logic [15:0] delay_cfg = DELAY_TICKS_RESET;
	int          fail_cnt = 0;
	int          results_seen = 0;
	int          items_made = 0;
	int          cycle_cnt = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	logic        quiet;

	i2c_master_acked_register_access uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.operation(operation),
		.device_byte(device_byte),
		.register_address(register_address),
		.write_value(write_value),
		.read_length(read_length),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.sda_enable(sda_enable),
		.busy_res(busy_res),
		.read_valid(read_valid),
		.read_data(read_data),
		.read_last(read_last),
		.done_res(done_res),
		.nack_error(nack_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// one stretch where neither side idles
	assign quiet = (cycle_cnt >= 300) && (cycle_cnt < 700);

	function automatic seq_state_t idle_state();
		seq_state_t s;
		s.step      = ST_IDLE;
		s.dcount    = '0;
		s.bit_idx   = '0;
		s.shreg     = '0;
		s.remaining = '0;
		s.dev       = '0;
		s.reg_addr  = '0;
		s.value     = '0;
		s.op        = 1'b0;
		s.scl       = 1'b1;
		s.sda       = 1'b1;
		s.en        = 1'b1;
		s.stage     = BS_DEVICE;
		s.aborted   = 1'b0;
		return s;
	endfunction

	function automatic void set_lines(inout seq_state_t s, input step_t st,
			input logic scl, input logic sda, input logic en);
		s.step = st;
		s.scl  = scl;
		s.sda  = sda;
		s.en   = en;
	endfunction

	function automatic void load_byte(inout seq_state_t s, input logic [7:0] v);
		s.shreg   = v;
		s.bit_idx = '0;
		set_lines(s, ST_TX_SET, 1'b0, v[7], 1'b1);
	endfunction

	// bus sequencer prediction for one item
	function automatic result_t predict_bus(inout seq_state_t s, input bus_item_t it,
			input logic [15:0] dticks);
		result_t     r;
		logic [16:0] lim;
		logic [8:0]  len;
		logic        last;
		r   = '0;
		lim = (dticks == 16'd0) ? 17'd1 : {1'b0, dticks};
		if (it.kind == KIND_CMD) begin
			if (s.step == ST_IDLE) begin
				len = it.rlen;
				if (len == 9'd0) len = 9'd1;
				if (len > MAX_READ_LENGTH_DEF) len = 9'(MAX_READ_LENGTH_DEF);
				s.op        = it.op;
				s.dev       = it.dev;
				s.reg_addr  = it.reg_addr;
				s.value     = it.value;
				s.remaining = len;
				s.stage     = BS_DEVICE;
				s.aborted   = 1'b0;
				s.dcount    = '0;
				s.bit_idx   = '0;
				s.shreg     = it.dev;
				set_lines(s, ST_START_A, 1'b1, 1'b1, 1'b1);
			end
		end else if (s.step != ST_IDLE) begin
			s.dcount = s.dcount + 16'd1;
			if ({1'b0, s.dcount} >= lim) begin
				s.dcount = '0;
				case (s.step)
					ST_START_A: set_lines(s, ST_START_B, 1'b1, 1'b0, 1'b1);
					ST_START_B: set_lines(s, ST_START_C, 1'b0, 1'b0, 1'b1);
					ST_START_C: begin
						s.bit_idx = '0;
						set_lines(s, ST_TX_SET, 1'b0, s.shreg[7], 1'b1);
					end
					ST_TX_SET: set_lines(s, ST_TX_HIGH, 1'b1, s.shreg[7], 1'b1);
					ST_TX_HIGH: begin
						s.shreg   = s.shreg << 1;
						s.bit_idx = s.bit_idx + 4'd1;
						if (s.bit_idx >= BYTE_BITS)
							set_lines(s, ST_ACK_SETUP, 1'b0, 1'b1, 1'b0);
						else
							set_lines(s, ST_TX_SET, 1'b0, s.shreg[7], 1'b1);
					end
					ST_ACK_SETUP: set_lines(s, ST_ACK_HIGH, 1'b1, 1'b1, 1'b0);
					ST_ACK_HIGH: begin
						if (it.sda) begin
							s.aborted = 1'b1;
							set_lines(s, ST_STOP_A, 1'b0, 1'b0, 1'b1);
						end else begin
							set_lines(s, ST_ACK_END, 1'b0, 1'b1, 1'b1);
						end
					end
					ST_ACK_END: begin
						case (s.stage)
							BS_DEVICE: begin
								s.stage = BS_REGISTER;
								load_byte(s, s.reg_addr);
							end
							BS_REGISTER: begin
								if (s.op == OP_WRITE) begin
									s.stage = BS_VALUE;
									load_byte(s, s.value);
								end else begin
									// repeated start with the read address
									s.stage = BS_READ_DEV;
									s.shreg = s.dev + 8'd1;
									set_lines(s, ST_START_A, 1'b1, 1'b1, 1'b1);
								end
							end
							BS_VALUE: set_lines(s, ST_STOP_A, 1'b0, 1'b0, 1'b1);
							default: begin
								s.bit_idx = '0;
								s.shreg   = '0;
								set_lines(s, ST_RX_LOW, 1'b0, 1'b1, 1'b0);
							end
						endcase
					end
					ST_RX_LOW: set_lines(s, ST_RX_HIGH, 1'b1, 1'b1, 1'b0);
					ST_RX_HIGH: begin
						s.shreg   = {s.shreg[6:0], it.sda};
						s.bit_idx = s.bit_idx + 4'd1;
						if (s.bit_idx >= BYTE_BITS)
							set_lines(s, ST_RACK_SET, 1'b0, s.remaining <= 9'd1, 1'b1);
						else
							set_lines(s, ST_RX_LOW, 1'b0, 1'b1, 1'b0);
					end
					ST_RACK_SET: set_lines(s, ST_RACK_HIGH, 1'b1, s.sda, 1'b1);
					ST_RACK_HIGH: begin
						last         = s.remaining <= 9'd1;
						r.read_valid = 1'b1;
						r.read_data  = s.shreg;
						r.read_last  = last;
						if (s.remaining != 9'd0) s.remaining = s.remaining - 9'd1;
						if (last) begin
							set_lines(s, ST_STOP_A, 1'b0, 1'b0, 1'b1);
						end else begin
							s.bit_idx = '0;
							s.shreg   = '0;
							set_lines(s, ST_RX_LOW, 1'b0, 1'b1, 1'b0);
						end
					end
					ST_STOP_A: set_lines(s, ST_STOP_B, 1'b1, 1'b0, 1'b1);
					ST_STOP_B: begin
						set_lines(s, ST_IDLE, 1'b1, 1'b1, 1'b1);
						r.done_res   = 1'b1;
						r.nack_error = s.aborted;
						s.aborted    = 1'b0;
					end
					default: set_lines(s, ST_IDLE, 1'b1, 1'b1, 1'b1);
				endcase
			end
		end
		r.scl_out    = s.scl;
		r.sda_out    = s.sda;
		r.sda_enable = s.en;
		r.busy_res   = s.step != ST_IDLE;
		return r;
	endfunction

	// sender: one transfer per accepted item, prediction taken at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted = predict_bus(check_state, cur_item, delay_cfg);
				bus_expect_q.push_back(predicted);
			end
			if (!in_valid || !in_stall) begin
				if (item_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
					cur_item = item_q.pop_front();
					in_valid         <= 1'b1;
					kind             <= cur_item.kind;
					operation        <= cur_item.op;
					device_byte      <= cur_item.dev;
					register_address <= cur_item.reg_addr;
					write_value      <= cur_item.value;
					read_length      <= cur_item.rlen;
					sda_in           <= cur_item.sda;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// receiver: compare and stall, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (bus_expect_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_cnt++;
				end else begin
					want = bus_expect_q.pop_front();
					check_field("scl_out", 8'(want.scl_out), 8'(scl_out));
					check_field("sda_out", 8'(want.sda_out), 8'(sda_out));
					check_field("sda_enable", 8'(want.sda_enable), 8'(sda_enable));
					check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
					check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
					check_field("read_data", want.read_data, read_data);
					check_field("read_last", 8'(want.read_last), 8'(read_last));
					check_field("done_res", 8'(want.done_res), 8'(done_res));
					check_field("nack_error", 8'(want.nack_error), 8'(nack_error));
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= 600) begin
				out_stall <= 1'b1;
				hold_left <= 120;
				hold_done <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 16);
			end
		end
	end

	task automatic push_item(input bus_item_t it);
		// ignored items do not count toward the stimulus size
		if ((it.kind == KIND_CMD) == (plan_state.step == ST_IDLE)) items_made++;
		item_q.push_back(it);
		void'(predict_bus(plan_state, it, delay_cfg));
	endtask

	task automatic push_tick(input int nack_stage);
		bus_item_t it;
		it      = bus_item_t'({$urandom, $urandom});
		it.kind = KIND_TICK;
		// slave answers the ack phase; elsewhere the line is random
		if (plan_state.step == ST_ACK_HIGH)
			it.sda = (int'(plan_state.stage) == nack_stage);
		push_item(it);
	endtask

	task automatic run_txn(input logic op, input logic [7:0] dev, input logic [7:0] ra,
			input logic [7:0] val, input logic [8:0] len, input int nack_stage);
		bus_item_t it;
		it.kind     = KIND_CMD;
		it.op       = op;
		it.dev      = dev;
		it.reg_addr = ra;
		it.value    = val;
		it.rlen     = len;
		it.sda      = 1'($urandom_range(0, 1));
		push_item(it);
		while (plan_state.step != ST_IDLE) begin
			if ($urandom_range(0, 99) < 2) begin
				// command while busy, must be dropped
				it      = bus_item_t'({$urandom, $urandom});
				it.kind = KIND_CMD;
				push_item(it);
			end
			push_tick(nack_stage);
		end
	endtask

	task automatic random_txn();
		logic       op;
		logic [8:0] len;
		int         pick;
		int         nack_stage;
		op   = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 85) len = 9'($urandom_range(0, 3));
		else if (pick < 98) len = 9'($urandom_range(4, 20));
		else len = 9'($urandom_range(21, 40));
		nack_stage = NO_NACK;
		if ($urandom_range(0, 99) < 8) begin
			nack_stage = $urandom_range(0, 2);
			if (op == OP_READ && nack_stage == int'(BS_VALUE)) nack_stage = int'(BS_READ_DEV);
		end
		repeat ($urandom_range(0, 2)) push_tick(NO_NACK);
		run_txn(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), len, nack_stage);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (item_q.size() != 0 || in_valid || bus_expect_q.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_delay(input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		delay_cfg = v;
	endtask

	initial begin
		bus_item_t it;
		int        target;
		plan_state  = idle_state();
		check_state = idle_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset delay: tick while idle, a write, a command while busy, one phase
		push_tick(NO_NACK);
		it = '{kind: KIND_CMD, op: OP_WRITE, dev: 8'h00, reg_addr: 8'h00, value: 8'h00,
			rlen: 9'd0, sda: 1'b0};
		push_item(it);
		it = '{kind: KIND_CMD, op: OP_READ, dev: 8'hFF, reg_addr: 8'hFF, value: 8'hFF,
			rlen: 9'h1FF, sda: 1'b1};
		push_item(it);
		repeat (103) push_tick(NO_NACK);
		wait_drained();

		// longest delay mid-phase, then zero delay shortens the running phase
		write_delay(16'hFFFF);
		repeat (5) push_tick(NO_NACK);
		wait_drained();
		write_delay(16'h0000);
		while (plan_state.step != ST_IDLE) push_tick(NO_NACK);

		run_txn(OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 9'd0, NO_NACK);
		run_txn(OP_READ, 8'hFE, 8'h00, 8'h00, 9'd0, NO_NACK);
		run_txn(OP_READ, 8'h40, 8'h10, 8'h00, 9'd3, NO_NACK);
		run_txn(OP_WRITE, 8'h20, 8'h01, 8'h80, 9'd1, int'(BS_DEVICE));
		run_txn(OP_WRITE, 8'h20, 8'h02, 8'h7F, 9'd1, int'(BS_REGISTER));
		run_txn(OP_WRITE, 8'h20, 8'h03, 8'hC3, 9'd1, int'(BS_VALUE));
		run_txn(OP_READ, 8'h30, 8'h04, 8'h00, 9'd2, int'(BS_REGISTER));
		run_txn(OP_READ, 8'h30, 8'h05, 8'h00, 9'd2, int'(BS_READ_DEV));
		wait_drained();

		// random traffic under a couple of bus speeds
		target = items_made;
		for (int p = 0; p < 2; p++) begin
			if (p == 0) write_delay(16'd1);
			else write_delay(16'($urandom_range(2, 4)));
			target += 1;
			while (items_made < target) random_txn();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("i2c_master_acked_register_access_tb: PASS");
		else
			$display("i2c_master_acked_register_access_tb: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("i2c_master_acked_register_access_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
src/i2cm_pkg.sv
src/i2cm_seq.sv
src/i2c_master_acked_register_access.sv
dv/i2c_master_acked_register_access_tb.sv
